FILE: rtl/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants of the bar chart layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package bcl_pkg;

  localparam int unsigned MaxPointsDefault = 32;
  localparam int unsigned DividendW        = 26;
  localparam int unsigned DivisorW         = 17;
  localparam int unsigned DivCntW          = 5;

  localparam logic [7:0] RegCanvasWidth  = 8'd0;
  localparam logic [7:0] RegCanvasHeight = 8'd1;
  localparam logic [7:0] RegLeftOffset   = 8'd2;
  localparam logic [7:0] RegAutoRange    = 8'd3;

  localparam logic [8:0]  FixedSpan   = 9'd8;
  localparam logic [15:0] SeedMin     = 16'sd0;
  localparam logic [15:0] SeedMax     = 16'sd1;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DividendW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/bcl_div.sv
// ----------------------------------------------------------------------------
// bcl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcl_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bcl_pkg::div_req_t req_i,
  output bcl_pkg::div_rsp_t     rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [bcl_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [bcl_pkg::DividendW-1:0]     quo_q, quo_d;
  logic [bcl_pkg::DivisorW:0]        rem_q, rem_d;
  logic [bcl_pkg::DivisorW-1:0]      dvs_q, dvs_d;
  logic [bcl_pkg::DivisorW:0]        rem_sh;
  logic [bcl_pkg::DivisorW+1:0]      diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[bcl_pkg::DivisorW-1:0], quo_q[bcl_pkg::DividendW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[bcl_pkg::DivisorW+1]) begin
        rem_d = diff[bcl_pkg::DivisorW:0];
        quo_d = {quo_q[bcl_pkg::DividendW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[bcl_pkg::DividendW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bcl_pkg::DivCntW'(bcl_pkg::DividendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/bar_chart_layout_top.sv
// ----------------------------------------------------------------------------
// bar_chart_layout_top
// Bar chart geometry: stores chart values, then emits one rectangle per bar.
// ----------------------------------------------------------------------------
// Values load at one item per cycle. On the last item the block stops taking
// items and lays out the chart with one shared divider: one division for the
// bar width, one for the zero baseline, then per bar one for the level and
// one for the color position, each bar then waiting for the receiver. Up to
// MAX_POINTS values are kept; later ones are dropped.
`default_nettype none

module bar_chart_layout_top #(
  parameter int unsigned MAX_POINTS = bcl_pkg::MaxPointsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [8:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic               final_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [9:0]              rect_x_o,
  output logic [8:0]              rect_top_o,
  output logic [8:0]              rect_width_o,
  output logic [8:0]              rect_height_o,
  output logic [8:0]              color_position_o,
  output logic                    final_bar_o
);

  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_BW, S_ZR, S_RD, S_LVGO, S_LV, S_CP, S_OUT
  } state_e;

  state_e state_q;

  logic [8:0]  cw_q, ch_q;
  logic [7:0]  x0_q;
  logic        auto_q;

  logic signed [15:0] mem [MAX_POINTS];
  logic signed [15:0] rd_q;

  logic [CntW-1:0]     cnt_q, idx_q;
  logic signed [15:0]  min_q, max_q;
  logic signed [15:0]  lo_q;
  logic [16:0]         span_q;
  logic [8:0]          bw_q, zero_q, lvl_q;
  logic [9:0]          x_q;

  bcl_pkg::div_req_t req_q;
  bcl_pkg::div_rsp_t rsp;

  logic               accept;
  logic signed [17:0] num;
  logic [25:0]        lvl_dividend;
  logic [8:0]         q_lvl;
  logic signed [9:0]  avail;
  logic signed [10:0] bw_num;
  logic signed [17:0] lo_ext, hi_ext;
  logic [8:0]         q_cp;
  logic [8:0]         hi_l;

  bcl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_LOAD);
  assign accept      = in_valid_i && !in_stall_o;

  assign num          = 18'(rd_q) - 18'(lo_q);
  assign lvl_dividend = num[17] ? '0 : 26'(num[16:0] * ch_q);
  assign q_lvl        = (rsp.quotient > 26'(ch_q)) ? ch_q : rsp.quotient[8:0];
  assign q_cp         = (rsp.quotient > 26'd256) ? 9'd256 : rsp.quotient[8:0];
  assign avail        = $signed({1'b0, cw_q}) - $signed({2'b00, x0_q});
  assign bw_num       = 11'(avail) - $signed({1'b0, 10'(cnt_q)}) + 11'sd1;
  assign lo_ext       = auto_q ? 18'(min_q) : '0;
  assign hi_ext       = auto_q ? 18'(max_q) : 18'(bcl_pkg::FixedSpan);
  assign hi_l         = (lvl_q > zero_q) ? lvl_q : zero_q;

  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q < CntW'(MAX_POINTS))) begin
      mem[cnt_q[AddrW-1:0]] <= sample_value_i;
    end
    rd_q <= mem[idx_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q        <= 9'd32;
      ch_q        <= 9'd8;
      x0_q        <= '0;
      auto_q      <= 1'b1;
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      idx_q       <= '0;
      min_q       <= bcl_pkg::SeedMin;
      max_q       <= bcl_pkg::SeedMax;
      req_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bcl_pkg::RegCanvasWidth:  cw_q   <= cfg_data_i;
          bcl_pkg::RegCanvasHeight: ch_q   <= cfg_data_i;
          bcl_pkg::RegLeftOffset:   x0_q   <= cfg_data_i[7:0];
          bcl_pkg::RegAutoRange:    auto_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (cnt_q < CntW'(MAX_POINTS)) begin
              cnt_q <= cnt_q + 1'b1;
              if (sample_value_i < min_q) min_q <= sample_value_i;
              if (sample_value_i > max_q) max_q <= sample_value_i;
            end
            if (final_sample_i) state_q <= S_START;
          end
        end
        S_START: begin
          if (cnt_q == '0 || avail <= 10'sd0) begin
            cnt_q   <= '0;
            min_q   <= bcl_pkg::SeedMin;
            max_q   <= bcl_pkg::SeedMax;
            state_q <= S_LOAD;
          end else begin
            lo_q           <= lo_ext[15:0];
            span_q         <= 17'(hi_ext - lo_ext);
            x_q            <= 10'(x0_q);
            idx_q          <= '0;
            req_q.start    <= 1'b1;
            req_q.dividend <= (bw_num > 11'sd0) ? 26'(bw_num[9:0]) : '0;
            req_q.divisor  <= 17'(cnt_q);
            state_q        <= S_BW;
          end
        end
        S_BW: begin
          if (rsp.done) begin
            bw_q           <= (rsp.quotient == '0) ? 9'd1 : rsp.quotient[8:0];
            req_q.start    <= 1'b1;
            req_q.dividend <= 26'(17'(-18'(lo_q)) * ch_q);
            req_q.divisor  <= span_q;
            state_q        <= S_ZR;
          end else begin
            req_q.start <= 1'b0;
          end
        end
        S_ZR: begin
          req_q.start <= 1'b0;
          if (rsp.done) begin
            zero_q  <= q_lvl;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_LVGO;
        S_LVGO: begin
          req_q.start    <= 1'b1;
          req_q.dividend <= lvl_dividend;
          req_q.divisor  <= span_q;
          state_q        <= S_LV;
        end
        S_LV: begin
          if (rsp.done) begin
            lvl_q          <= q_lvl;
            req_q.start    <= 1'b1;
            req_q.dividend <= (num[17] || num == '0) ? '0 : {1'b0, num[16:0], 8'h00};
            req_q.divisor  <= span_q;
            state_q        <= S_CP;
          end else begin
            req_q.start <= 1'b0;
          end
        end
        S_CP: begin
          req_q.start <= 1'b0;
          if (rsp.done) begin
            rect_x_o         <= x_q;
            rect_top_o       <= ch_q - hi_l;
            rect_width_o     <= bw_q;
            rect_height_o    <= (lvl_q > zero_q) ? lvl_q - zero_q : zero_q - lvl_q;
            color_position_o <= q_cp;
            final_bar_o      <= (idx_q + 1'b1 == cnt_q);
            out_valid_o      <= 1'b1;
            state_q          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            if (idx_q + 1'b1 == cnt_q) begin
              cnt_q   <= '0;
              idx_q   <= '0;
              min_q   <= bcl_pkg::SeedMin;
              max_q   <= bcl_pkg::SeedMax;
              state_q <= S_LOAD;
            end else begin
              idx_q   <= idx_q + 1'b1;
              x_q     <= x_q + 10'(bw_q) + 10'd1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("item taken while a bar waits");
  a_width_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rect_width_o != 9'd0) else $error("zero bar width");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.start |-> !rsp.busy) else $error("divider restarted while busy");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < cnt_q) else $error("bar index past count");
`endif

endmodule

`default_nettype wire
